### hdl/tqla_pkg.sv
package tqla_pkg;

    localparam int IDX_W    = 10;
    localparam int ACT_W    = 3;
    localparam int LINK_W   = 8;
    localparam int OP_W     = 2;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 2;
    localparam int DRAW_W   = 16;
    localparam int PICK_W   = 15;
    localparam int Q_W      = 32;

    typedef logic [OP_W-1:0]      t_op;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    typedef logic [CFG_W-1:0]     t_cfg_word;

    localparam t_op OP_CHOOSE = 2'd0;
    localparam t_op OP_UPDATE = 2'd1;
    localparam t_op OP_GREEDY = 2'd2;

    localparam t_cfg_idx CFG_LEARN_RATE   = 2'd0;
    localparam t_cfg_idx CFG_DISCOUNT     = 2'd1;
    localparam t_cfg_idx CFG_EXPLORE_RATE = 2'd2;

    localparam t_cfg_word LEARN_RATE_RST   = 16'd13107;
    localparam t_cfg_word DISCOUNT_RST     = 16'd58982;
    localparam t_cfg_word EXPLORE_RATE_RST = 16'd65535;

    // largest epsilon still below 0.02 in Q0.16
    localparam t_cfg_word EPS_FLOOR = 16'd1310;

endpackage

### hdl/tabular_q_learning_agent.sv
// Channel  | Direction | Handshake                   | Beat contents
// input    | in        | i_in_valid / o_in_ready     | action, indices, reward, draws
// output   | out       | o_out_valid / i_out_ready   | chosen_action, explored, new_q
// config   | in        | i_cfg_we (no wait)          | i_cfg_index, i_cfg_data
//
// One item is worked at a time. Choose and greedy scan a row on the single read port of the
// Q table; explore takes the pick draw modulo the link count (skipped with no links);
// update scans the next row (a first touch of a row zero-fills it one word a cycle).
// When NUM_STATES is below 1024 and not a power of two, the indices are first wrapped.
// After reset the row valid memory is cleared for all NUM_STATES rows; no beat is taken then.
// A finished result waits in the output register while the next beat is accepted.
module tabular_q_learning_agent #(
    parameter int NUM_STATES   = 1024,
    parameter int ACTION_COUNT = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,

    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  tqla_pkg::t_op               i_action,
    input  logic [tqla_pkg::IDX_W-1:0]  i_state_index,
    input  logic [tqla_pkg::LINK_W-1:0] i_link_count,
    input  logic [tqla_pkg::ACT_W-1:0]  i_act_index,
    input  logic signed [tqla_pkg::Q_W-1:0] i_reward,
    input  logic [tqla_pkg::IDX_W-1:0]  i_next_state_index,
    input  logic [tqla_pkg::DRAW_W-1:0] i_explore_draw,
    input  logic [tqla_pkg::PICK_W-1:0] i_pick_draw,

    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [tqla_pkg::ACT_W-1:0]  o_chosen_action,
    output logic                        o_explored,
    output logic signed [tqla_pkg::Q_W-1:0] o_new_q,

    input  logic                        i_cfg_we,
    input  tqla_pkg::t_cfg_idx          i_cfg_index,
    input  tqla_pkg::t_cfg_word         i_cfg_data
);
    import tqla_pkg::*;

    localparam int SW  = $clog2(NUM_STATES);
    localparam int AW  = $clog2(ACTION_COUNT);
    localparam int QAW = SW + AW;
    localparam int WS  = IDX_W + SW;
    localparam bit ST_WRAP = (NUM_STATES < (1 << IDX_W)) &&
                             ((NUM_STATES & (NUM_STATES - 1)) != 0);
    localparam logic [IDX_W-1:0]  ST_DEN   = IDX_W'(NUM_STATES);
    localparam logic [IDX_W+1:0]  W_MUL    =
        (IDX_W+2)'(((1 << WS) + NUM_STATES - 1) / NUM_STATES);
    localparam logic [SW-1:0]     ST_LAST  = SW'(NUM_STATES - 1);
    localparam logic [AW:0]       K_END    = (AW+1)'(ACTION_COUNT);
    localparam logic [AW:0]       K_LAST   = (AW+1)'(ACTION_COUNT - 1);
    localparam logic [AW-1:0]     KD_LAST  = AW'(ACTION_COUNT - 1);
    localparam logic [LINK_W-1:0] LINK_MAX = LINK_W'(ACTION_COUNT);
    localparam logic [ACT_W+4-1:0] ACT_LIM = (ACT_W+4)'(ACTION_COUNT);
    localparam logic [3:0]        CNT_PICK = 4'(PICK_W);
    localparam logic signed [35:0] SAT_MAX = 36'sd2147483647;
    localparam logic signed [35:0] SAT_MIN = -36'sd2147483648;

    typedef enum logic [4:0] {
        S_CLR, S_IDLE, S_REM, S_WMUL, S_WSUB, S_VST, S_VNST, S_VCHK, S_SCAN,
        S_ROWPREP, S_FILL, S_QRD, S_QWAIT, S_MUL1, S_RND, S_TD, S_DIFF, S_MUL2,
        S_SUM, S_SAT, S_DONE
    } t_state;

    t_state   r_state;

    logic [CFG_W-1:0] r_alpha;
    logic [CFG_W-1:0] r_gamma;
    logic [CFG_W-1:0] r_eps;

    logic [Q_W-1:0] r_q_mem [(1 << QAW)];
    logic           r_v_mem [NUM_STATES];
    logic [Q_W-1:0] r_q_rd;
    logic           r_v_rd;

    logic [SW-1:0]  r_clr;
    t_op            r_op;
    logic [IDX_W-1:0] r_st;
    logic [IDX_W-1:0] r_nst;
    logic [ACT_W-1:0] r_act;
    logic signed [Q_W-1:0] r_reward;

    logic [PICK_W-1:0] r_num;
    logic [IDX_W-1:0]  r_den;
    logic [IDX_W-1:0]  r_rem;
    logic [3:0]        r_cnt;

    logic [IDX_W-1:0]  r_wq_st;
    logic [IDX_W-1:0]  r_wq_nst;

    logic              r_st_vld;
    logic              r_scan_nst;
    logic [AW:0]       r_k;
    logic [AW-1:0]     r_kd;
    logic              r_pend;
    logic signed [Q_W-1:0] r_best;
    logic [AW-1:0]     r_bidx;
    logic signed [Q_W-1:0] r_bnext;
    logic signed [Q_W-1:0] r_q;

    logic signed [48:0] r_p1;
    logic signed [32:0] r_rnd;
    logic signed [33:0] r_td;
    logic signed [33:0] r_diff;
    logic [32:0]        r_pl;
    logic signed [33:0] r_ph;
    logic signed [34:0] r_delta;

    logic [ACT_W-1:0]      r_res_chosen;
    logic                  r_res_explored;
    logic signed [Q_W-1:0] r_res_newq;

    logic                  r_out_valid;
    logic [ACT_W-1:0]      r_out_chosen;
    logic                  r_out_explored;
    logic signed [Q_W-1:0] r_out_newq;

    logic [SW-1:0]      st_idx;
    logic [SW-1:0]      nst_idx;
    logic [SW-1:0]      scan_row;
    logic [AW-1:0]      act_aw;
    logic               explore;
    logic [LINK_W-1:0]  span;
    logic               act_ok;
    logic [IDX_W:0]     rem_t;
    logic               rem_ge;
    logic [IDX_W-1:0]   n_rem;
    logic [2*IDX_W+1:0] wp_st;
    logic [2*IDX_W+1:0] wp_nst;
    logic               scan_take;
    logic signed [Q_W-1:0] cand_best;
    logic [AW-1:0]      cand_idx;
    logic               scan_last;
    logic signed [48:0] p1;
    logic signed [48:0] p1r;
    logic [32:0]        pl;
    logic signed [33:0] ph;
    logic signed [50:0] prod;
    logic signed [35:0] res;
    logic signed [Q_W-1:0] sat_q;

    logic             q_we;
    logic [QAW-1:0]   q_waddr;
    logic [Q_W-1:0]   q_wdata;
    logic [QAW-1:0]   q_raddr;
    logic             v_we;
    logic [SW-1:0]    v_waddr;
    logic             v_wdata;
    logic [SW-1:0]    v_raddr;

    assign st_idx   = SW'(r_st);
    assign nst_idx  = SW'(r_nst);
    assign scan_row = r_scan_nst ? nst_idx : st_idx;
    assign act_aw   = AW'(r_act);

    assign explore = (i_explore_draw < r_eps) && (r_eps > EPS_FLOOR);
    assign span    = (i_link_count < LINK_MAX) ? i_link_count : LINK_MAX;
    assign act_ok  = {4'b0, i_act_index} < ACT_LIM;

    assign rem_t  = {r_rem, r_num[PICK_W-1]};
    assign rem_ge = rem_t >= {1'b0, r_den};
    assign n_rem  = rem_ge ? IDX_W'(rem_t - {1'b0, r_den}) : rem_t[IDX_W-1:0];

    assign wp_st  = r_st * W_MUL;
    assign wp_nst = r_nst * W_MUL;

    assign scan_take = r_pend && ((r_kd == '0) || ($signed(r_q_rd) > r_best));
    assign cand_best = scan_take ? $signed(r_q_rd) : r_best;
    assign cand_idx  = scan_take ? r_kd : r_bidx;
    assign scan_last = r_pend && (r_kd == KD_LAST);

    assign p1   = $signed({1'b0, r_gamma}) * r_bnext;
    assign p1r  = r_p1 + 49'sd32768;
    assign pl   = r_alpha * r_diff[16:0];
    assign ph   = $signed({1'b0, r_alpha}) * $signed(r_diff[33:17]);
    assign prod = $signed({r_ph, 17'b0}) + $signed({18'b0, r_pl});
    assign res  = $signed({{4{r_q[31]}}, r_q}) + $signed({r_delta[34], r_delta});

    always_comb begin
        if (res > SAT_MAX) begin
            sat_q = SAT_MAX[Q_W-1:0];
        end else if (res < SAT_MIN) begin
            sat_q = SAT_MIN[Q_W-1:0];
        end else begin
            sat_q = res[Q_W-1:0];
        end
    end

    always_comb begin
        q_we    = 1'b0;
        q_waddr = {st_idx, act_aw};
        q_wdata = sat_q;
        if (r_state == S_FILL) begin
            q_we    = 1'b1;
            q_waddr = {st_idx, r_k[AW-1:0]};
            q_wdata = '0;
        end else if (r_state == S_SAT) begin
            q_we    = 1'b1;
        end
    end

    assign q_raddr = (r_state == S_SCAN) ? {scan_row, r_k[AW-1:0]} : {st_idx, act_aw};

    always_comb begin
        v_we    = 1'b0;
        v_waddr = st_idx;
        v_wdata = 1'b1;
        if (r_state == S_CLR) begin
            v_we    = 1'b1;
            v_waddr = r_clr;
            v_wdata = 1'b0;
        end else if (r_state == S_FILL && r_k == K_LAST) begin
            v_we    = 1'b1;
        end
    end

    assign v_raddr = (r_state == S_VNST) ? nst_idx : st_idx;

    always_ff @(posedge i_clk) begin
        if (q_we) begin
            r_q_mem[q_waddr] <= q_wdata;
        end
        r_q_rd <= r_q_mem[q_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (v_we) begin
            r_v_mem[v_waddr] <= v_wdata;
        end
        r_v_rd <= r_v_mem[v_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha <= LEARN_RATE_RST;
            r_gamma <= DISCOUNT_RST;
            r_eps   <= EXPLORE_RATE_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_LEARN_RATE:   r_alpha <= i_cfg_data;
                CFG_DISCOUNT:     r_gamma <= i_cfg_data;
                CFG_EXPLORE_RATE: r_eps   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_CLR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == ST_LAST) begin
                        r_state <= S_IDLE;
                    end
                end

                S_IDLE: begin
                    if (i_in_valid) begin
                        r_op           <= i_action;
                        r_st           <= i_state_index;
                        r_nst          <= i_next_state_index;
                        r_act          <= i_act_index;
                        r_reward       <= i_reward;
                        r_res_chosen   <= '0;
                        r_res_explored <= (i_action == OP_CHOOSE) && explore;
                        r_res_newq     <= '0;
                        r_num          <= i_pick_draw;
                        r_den          <= IDX_W'(span);
                        r_rem          <= '0;
                        r_cnt          <= CNT_PICK;
                        unique case (i_action) inside
                            OP_CHOOSE, OP_GREEDY, OP_UPDATE: begin
                                if (i_action == OP_CHOOSE && explore) begin
                                    if (span != '0) begin
                                        r_state <= S_REM;
                                    end else begin
                                        r_state <= S_DONE;
                                    end
                                end else if (i_action != OP_UPDATE || act_ok) begin
                                    if (ST_WRAP) begin
                                        r_state <= S_WMUL;
                                    end else begin
                                        r_state <= S_VST;
                                    end
                                end else begin
                                    r_state <= S_DONE;
                                end
                            end
                            default: r_state <= S_DONE;
                        endcase
                    end
                end

                S_REM: begin
                    r_rem <= n_rem;
                    r_num <= {r_num[PICK_W-2:0], 1'b0};
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == 4'd1) begin
                        r_res_chosen <= n_rem[ACT_W-1:0];
                        r_state      <= S_DONE;
                    end
                end

                S_WMUL: begin
                    r_wq_st  <= IDX_W'(wp_st >> WS);
                    r_wq_nst <= IDX_W'(wp_nst >> WS);
                    r_state  <= S_WSUB;
                end

                S_WSUB: begin
                    r_st    <= r_st - IDX_W'(r_wq_st * ST_DEN);
                    r_nst   <= r_nst - IDX_W'(r_wq_nst * ST_DEN);
                    r_state <= S_VST;
                end

                S_VST: begin
                    r_state <= S_VNST;
                end

                S_VNST: begin
                    r_st_vld   <= r_v_rd;
                    r_scan_nst <= 1'b0;
                    r_k        <= '0;
                    r_pend     <= 1'b0;
                    if (r_op == OP_UPDATE) begin
                        r_state <= S_VCHK;
                    end else if (r_v_rd) begin
                        r_state <= S_SCAN;
                    end else begin
                        r_state <= S_DONE;
                    end
                end

                S_VCHK: begin
                    if (r_v_rd) begin
                        r_scan_nst <= 1'b1;
                        r_state    <= S_SCAN;
                    end else begin
                        r_bnext <= '0;
                        r_state <= S_ROWPREP;
                    end
                end

                S_SCAN: begin
                    if (r_k != K_END) begin
                        r_k <= r_k + 1'b1;
                    end
                    r_pend <= (r_k != K_END);
                    r_kd   <= r_k[AW-1:0];
                    if (r_pend) begin
                        r_best <= cand_best;
                        r_bidx <= cand_idx;
                    end
                    if (scan_last) begin
                        if (r_op == OP_UPDATE) begin
                            r_bnext <= cand_best;
                            r_state <= S_ROWPREP;
                        end else begin
                            r_res_chosen <= ACT_W'(cand_idx);
                            r_state      <= S_DONE;
                        end
                    end
                end

                S_ROWPREP: begin
                    r_k <= '0;
                    if (r_st_vld) begin
                        r_state <= S_QRD;
                    end else begin
                        r_state <= S_FILL;
                    end
                end

                S_FILL: begin
                    r_k <= r_k + 1'b1;
                    if (r_k == K_LAST) begin
                        r_q     <= '0;
                        r_state <= S_MUL1;
                    end
                end

                S_QRD: begin
                    r_state <= S_QWAIT;
                end

                S_QWAIT: begin
                    r_q     <= $signed(r_q_rd);
                    r_state <= S_MUL1;
                end

                S_MUL1: begin
                    r_p1    <= p1;
                    r_state <= S_RND;
                end

                S_RND: begin
                    r_rnd   <= p1r[48:16];
                    r_state <= S_TD;
                end

                S_TD: begin
                    r_td    <= $signed({{2{r_reward[31]}}, r_reward})
                             + $signed({r_rnd[32], r_rnd});
                    r_state <= S_DIFF;
                end

                S_DIFF: begin
                    r_diff  <= r_td - $signed({{2{r_q[31]}}, r_q});
                    r_state <= S_MUL2;
                end

                S_MUL2: begin
                    r_pl    <= pl;
                    r_ph    <= ph;
                    r_state <= S_SUM;
                end

                S_SUM: begin
                    r_delta <= prod[50:16];
                    r_state <= S_SAT;
                end

                S_SAT: begin
                    r_res_newq <= sat_q;
                    r_state    <= S_DONE;
                end

                S_DONE: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid    <= 1'b1;
                        r_out_chosen   <= r_res_chosen;
                        r_out_explored <= r_res_explored;
                        r_out_newq     <= r_res_newq;
                        r_state        <= S_IDLE;
                    end
                end

                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_ready      = (r_state == S_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_chosen_action = r_out_chosen;
    assign o_explored      = r_out_explored;
    assign o_new_q         = r_out_newq;

endmodule
